// ===== hw/rtl/pfp_pkg.sv =====
// shared types and constants for the pose frame parser
package pfp_pkg;

    localparam int PAYLOAD_BYTES = 24;
    localparam int NUM_WORDS     = PAYLOAD_BYTES / 4;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int MASK_W        = 5;

    localparam logic [7:0] HDR_FIRST  = 8'h0D;
    localparam logic [7:0] HDR_SECOND = 8'h0A;
    localparam logic [7:0] TRL_FIRST  = 8'h0A;
    localparam logic [7:0] TRL_SECOND = 8'h0D;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    // payload word order
    localparam int W_YAW   = 0;
    localparam int W_PITCH = 1;
    localparam int W_ROLL  = 2;
    localparam int W_A     = 3;
    localparam int W_B     = 4;
    localparam int W_RATE  = 5;

    // update mask bits
    localparam int M_POS   = 0;
    localparam int M_YAW   = 1;
    localparam int M_PITCH = 2;
    localparam int M_ROLL  = 3;
    localparam int M_RATE  = 4;

    localparam logic [MASK_W-1:0] MASK_RESET = 5'b11111;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_DATA = 5'b00100,
        PH_TRL1 = 5'b01000,
        PH_TRL2 = 5'b10000
    } phase_t;

    typedef logic [NUM_WORDS-1:0][31:0] word_arr_t;

    typedef struct packed {
        logic      commit;
        word_arr_t words;
    } frame_t;

endpackage

// ===== hw/rtl/pfp_framer.sv =====
// byte framing state machine and payload byte store
module pfp_framer import pfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_acc,
    input  logic [7:0] rx_byte,
    output frame_t     frame
);

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       store_reg [PAYLOAD_BYTES];
    logic             store_we;
    logic             commit;

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        store_we   = 1'b0;
        commit     = 1'b0;
        case (phase_reg)
            PH_HUNT: begin
                phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
            PH_HDR2: begin
                if (rx_byte == HDR_SECOND) begin
                    idx_next   = '0;
                    phase_next = PH_DATA;
                end else if (rx_byte != HDR_FIRST) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DATA: begin
                store_we = 1'b1;
                if (idx_reg >= LAST_IDX) begin
                    idx_next   = '0;
                    phase_next = PH_TRL1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            PH_TRL1: begin
                phase_next = (rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
            end
            PH_TRL2: begin
                phase_next = PH_HUNT;
                commit     = (rx_byte == TRL_SECOND);
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
        end else if (byte_acc) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // no reset: every byte is written before a commit reads it
    always_ff @(posedge aclk) begin
        if (byte_acc && store_we) begin
            store_reg[idx_reg] <= rx_byte;
        end
    end

    // little-endian words
    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            frame.words[w] = {store_reg[4*w+3], store_reg[4*w+2],
                              store_reg[4*w+1], store_reg[4*w]};
        end
        frame.commit = byte_acc && commit;
    end

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("frame phase not one-hot");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("payload index out of range");

    a_data_end: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_acc && phase_reg == PH_DATA && idx_reg == LAST_IDX |=> phase_reg == PH_TRL1)
        else $error("payload phase did not end after last byte");

endmodule

// ===== hw/rtl/pfp_pose.sv =====
// pose registers with update mask, doubling as the result register
module pfp_pose import pfp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    input  frame_t            frame,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [31:0]       x_bits,
    output logic [31:0]       y_bits,
    output logic [31:0]       yaw_bits,
    output logic [31:0]       pitch_bits,
    output logic [31:0]       roll_bits,
    output logic [31:0]       rate_bits
);

    logic [MASK_W-1:0] mask_reg;
    logic              valid_reg;
    logic [31:0]       x_reg, y_reg, yaw_reg, pitch_reg, roll_reg, rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MASK_RESET;
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (frame.commit) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg     <= '0;
            y_reg     <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
            roll_reg  <= '0;
            rate_reg  <= '0;
        end else if (frame.commit) begin
            if (mask_reg[M_POS]) begin
                x_reg <= frame.words[W_B];
                y_reg <= frame.words[W_A] ^ 32'h8000_0000;
            end
            if (mask_reg[M_YAW]) begin
                yaw_reg <= frame.words[W_YAW];
            end
            if (mask_reg[M_PITCH]) begin
                pitch_reg <= frame.words[W_PITCH];
            end
            if (mask_reg[M_ROLL]) begin
                roll_reg <= frame.words[W_ROLL];
            end
            if (mask_reg[M_RATE]) begin
                rate_reg <= frame.words[W_RATE];
            end
        end
    end

    assign out_valid  = valid_reg;
    assign x_bits     = x_reg;
    assign y_bits     = y_reg;
    assign yaw_bits   = yaw_reg;
    assign pitch_bits = pitch_reg;
    assign roll_bits  = roll_reg;
    assign rate_bits  = rate_reg;

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        frame.commit |=> valid_reg)
        else $error("committed frame not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |-> !frame.commit)
        else $error("pending result overwritten");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(frame.commit) |-> $stable(x_reg) && $stable(yaw_reg) && $stable(rate_reg))
        else $error("pose changed without a commit");

endmodule

// ===== hw/rtl/pose_frame_parser.sv =====
// top level of the pose frame parser
// Takes one received byte per cycle while s_ready is high and hunts for frames
// of 0x0D 0x0A, 24 payload bytes, 0x0A 0x0D. Each byte is handled in the cycle
// it is accepted, so the rate is one byte per cycle unless a result stalls it.
// A completed frame loads the enabled pose groups and presents all six pose
// words from the result register in the cycle after the closing byte; while
// that result waits unread, the next byte is still taken as it is drained.
// update_mask may be written at any time the block is idle.
module pose_frame_parser import pfp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_x_bits,
    output logic [31:0]       m_y_bits,
    output logic [31:0]       m_yaw_bits,
    output logic [31:0]       m_pitch_bits,
    output logic [31:0]       m_roll_bits,
    output logic [31:0]       m_rate_bits
);

    frame_t frame;
    logic   byte_acc;

    // a byte is taken unless a result is stuck at the output
    assign s_ready  = !m_valid || m_ready;
    assign byte_acc = s_valid && s_ready;

    pfp_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_acc(byte_acc),
        .rx_byte (s_rx_byte),
        .frame   (frame)
    );

    pfp_pose u_pose (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .frame      (frame),
        .out_ready  (m_ready),
        .out_valid  (m_valid),
        .x_bits     (m_x_bits),
        .y_bits     (m_y_bits),
        .yaw_bits   (m_yaw_bits),
        .pitch_bits (m_pitch_bits),
        .roll_bits  (m_roll_bits),
        .rate_bits  (m_rate_bits)
    );

endmodule
